FILE: sv/ldif_record_unfolder_macros.svh
// Assertion macros for the checker file.
`ifndef LDIF_RECORD_UNFOLDER_MACROS_SVH
`define LDIF_RECORD_UNFOLDER_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define LDIFRU_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define LDIFRU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ldifru_pkg.sv
package ldifru_pkg;

  // Characters with a meaning of their own in the text stream.
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_HASH    = 8'h23;

  // Codes for the way a record ended.
  localparam logic [1:0] END_BLANK_LINE  = 2'd0;
  localparam logic [1:0] END_EOI_RECORD  = 2'd1;
  localparam logic [1:0] END_EOI_NOTHING = 2'd2;

  // One result beat.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       record_end;
    logic [1:0] end_kind;
  } result_t;

  // A kept character.
  function automatic result_t mk_byte(logic [7:0] b);
    result_t r;
    r.out_byte   = b;
    r.record_end = 1'b0;
    r.end_kind   = END_BLANK_LINE;
    return r;
  endfunction

  // An end-of-record marker.
  function automatic result_t mk_end(logic [1:0] kind);
    result_t r;
    r.out_byte   = 8'h00;
    r.record_end = 1'b1;
    r.end_kind   = kind;
    return r;
  endfunction

endpackage

FILE: sv/ldifru_if.sv
// Text stream channel: one byte or an end-of-input mark per beat.
interface ldifru_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

// Record channel: one kept byte or an end marker per beat.
interface ldifru_rec_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       record_end;
  logic [1:0] end_kind;

  modport source (output valid, output out_byte, output record_end, output end_kind,
                  input ready);
  modport sink   (input valid, input out_byte, input record_end, input end_kind,
                  output ready);
endinterface

FILE: sv/ldif_record_unfolder.sv
// Channel   Direction  Payload
// text      sink       in_byte[7:0], end_of_input
// rec       source     out_byte[7:0], record_end, end_kind[1:0]
//
// One text beat is taken per cycle while text.ready is high; its results appear in the cycle after.
// A beat that gives two results (held newline plus a byte, or plus an end
// marker) fills the two-entry result buffer, so text stalls until rec takes the first.
// text.ready is high when the buffer is empty, or holds one beat that rec takes.
// Reset (rst, synchronous) clears the unfolding state and empties the buffer.
module ldif_record_unfolder (
  input  logic                clk,
  input  logic                rst,
  ldifru_text_if.sink         text,
  ldifru_rec_if.source        rec
);

  // Unfolding state.
  logic inside_comment, inside_comment_next;
  logic held_newline, held_newline_next;
  logic record_nonempty, record_nonempty_next;
  logic anything_read, anything_read_next;

  // Result buffer: entry 0 is the head.
  ldifru_pkg::result_t buf0, buf1;
  logic [1:0]          count;

  ldifru_pkg::result_t res0, res1;
  logic [1:0]          res_n;
  logic                accept, pop;

  assign pop         = rec.valid && rec.ready;
  assign text.ready  = (count == 2'd0) || ((count == 2'd1) && rec.ready);
  assign accept      = text.valid && text.ready;

  assign rec.valid      = (count != 2'd0);
  assign rec.out_byte   = buf0.out_byte;
  assign rec.record_end = buf0.record_end;
  assign rec.end_kind   = buf0.end_kind;

  // Results and next state for the beat at the input.
  always_comb begin
    res0                 = ldifru_pkg::mk_byte(8'h00);
    res1                 = ldifru_pkg::mk_byte(8'h00);
    res_n                = 2'd0;
    inside_comment_next  = inside_comment;
    held_newline_next    = held_newline;
    record_nonempty_next = record_nonempty;
    anything_read_next   = anything_read;
    if (text.end_of_input) begin
      if (held_newline) begin
        res0  = ldifru_pkg::mk_byte(ldifru_pkg::CH_NEWLINE);
        res1  = ldifru_pkg::mk_end(anything_read ? ldifru_pkg::END_EOI_RECORD
                                                 : ldifru_pkg::END_EOI_NOTHING);
        res_n = 2'd2;
      end else begin
        res0  = ldifru_pkg::mk_end(anything_read ? ldifru_pkg::END_EOI_RECORD
                                                 : ldifru_pkg::END_EOI_NOTHING);
        res_n = 2'd1;
      end
      inside_comment_next  = 1'b0;
      held_newline_next    = 1'b0;
      record_nonempty_next = 1'b0;
      anything_read_next   = 1'b0;
    end else begin
      anything_read_next = 1'b1;
      if (inside_comment) begin
        if (text.in_byte == ldifru_pkg::CH_NEWLINE) begin
          inside_comment_next = 1'b0;
        end
      end else if (text.in_byte == ldifru_pkg::CH_SPACE && held_newline) begin
        // Continuation line: the newline and the space both vanish.
        held_newline_next = 1'b0;
      end else if (text.in_byte == ldifru_pkg::CH_NEWLINE && held_newline) begin
        // Blank line closes the record.
        res0                 = ldifru_pkg::mk_end(ldifru_pkg::END_BLANK_LINE);
        res_n                = 2'd1;
        inside_comment_next  = 1'b0;
        held_newline_next    = 1'b0;
        record_nonempty_next = 1'b0;
        anything_read_next   = 1'b0;
      end else if (text.in_byte == ldifru_pkg::CH_HASH &&
                   (!record_nonempty || held_newline)) begin
        inside_comment_next = 1'b1;
      end else if (text.in_byte == ldifru_pkg::CH_NEWLINE && !record_nonempty) begin
        // Leading blank lines are skipped.
      end else begin
        record_nonempty_next = 1'b1;
        if (held_newline) begin
          // The byte here is never a newline, so both go out.
          res0              = ldifru_pkg::mk_byte(ldifru_pkg::CH_NEWLINE);
          res1              = ldifru_pkg::mk_byte(text.in_byte);
          res_n             = 2'd2;
          held_newline_next = 1'b0;
        end else if (text.in_byte == ldifru_pkg::CH_NEWLINE) begin
          held_newline_next = 1'b1;
        end else begin
          res0  = ldifru_pkg::mk_byte(text.in_byte);
          res_n = 2'd1;
        end
      end
    end
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      inside_comment  <= 1'b0;
      held_newline    <= 1'b0;
      record_nonempty <= 1'b0;
      anything_read   <= 1'b0;
      count           <= 2'd0;
    end else if (accept) begin
      // Accepting implies the buffer is empty after this cycle's pop.
      inside_comment  <= inside_comment_next;
      held_newline    <= held_newline_next;
      record_nonempty <= record_nonempty_next;
      anything_read   <= anything_read_next;
      count           <= res_n;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  // Buffer payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      buf0 <= res0;
      buf1 <= res1;
    end else if (pop) begin
      buf0 <= buf1;
    end
  end

endmodule

FILE: sv/ldifru_checker.sv
`include "ldif_record_unfolder_macros.svh"

module ldifru_checker (
  input logic       clk,
  input logic       rst,
  input logic       text_valid,
  input logic       text_ready,
  input logic       text_eoi,
  input logic       rec_valid,
  input logic       rec_ready,
  input logic [7:0] rec_byte,
  input logic       rec_end,
  input logic [1:0] rec_kind
);

  // A stalled result beat keeps its contents.
  `LDIFRU_ASSERT_NEXT(a_rec_hold, clk, rst, rec_valid && !rec_ready, rec_valid && $stable(rec_byte) && $stable(rec_end) && $stable(rec_kind), "result beat changed while stalled")

  // End of input always produces at least one result beat.
  `LDIFRU_ASSERT_NEXT(a_eoi_result, clk, rst, text_valid && text_ready && text_eoi, rec_valid, "end of input gave no result")

  // Byte beats carry no end kind.
  `LDIFRU_ASSERT_IMPLY(a_byte_kind, clk, rst, rec_valid && !rec_end, rec_kind == ldifru_pkg::END_BLANK_LINE, "byte beat with end kind set")

  // End markers carry a zero byte and a defined kind.
  `LDIFRU_ASSERT_IMPLY(a_end_form, clk, rst, rec_valid && rec_end, rec_byte == 8'h00 && rec_kind <= ldifru_pkg::END_EOI_NOTHING, "malformed end marker")

  // With nothing buffered the text side is open.
  `LDIFRU_ASSERT_IMPLY(a_idle_ready, clk, rst, !rec_valid, text_ready, "text stalled with empty buffer")

endmodule

bind ldif_record_unfolder ldifru_checker u_ldifru_checker (
  .clk        (clk),
  .rst        (rst),
  .text_valid (text.valid),
  .text_ready (text.ready),
  .text_eoi   (text.end_of_input),
  .rec_valid  (rec.valid),
  .rec_ready  (rec.ready),
  .rec_byte   (rec.out_byte),
  .rec_end    (rec.record_end),
  .rec_kind   (rec.end_kind)
);

FILE: test/tb_top.sv
module tb_top;

  localparam int RANDOM_ITEMS = 1750;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int N_DIRECTED   = 26;

  // The end_kind field carries no meaning in a byte beat.
  localparam logic [1:0] NO_KIND = 2'd0;

  localparam ldifru_pkg::result_t NO_BEAT          = '0;
  localparam ldifru_pkg::result_t BLANK_MARK       =
    {8'h00, 1'b1, ldifru_pkg::END_BLANK_LINE};
  localparam ldifru_pkg::result_t EOI_RECORD_MARK  =
    {8'h00, 1'b1, ldifru_pkg::END_EOI_RECORD};
  localparam ldifru_pkg::result_t EOI_NOTHING_MARK =
    {8'h00, 1'b1, ldifru_pkg::END_EOI_NOTHING};
  localparam ldifru_pkg::result_t NEWLINE_BYTE     =
    {ldifru_pkg::CH_NEWLINE, 1'b0, NO_KIND};

  // One text beat as offered, with its record beats where they are written out by hand.
  typedef struct packed {
    logic [7:0]          data;
    logic                eoi;
    logic                typed;
    logic [1:0]          n_res;
    ldifru_pkg::result_t r0;
    ldifru_pkg::result_t r1;
  } text_beat_t;

  logic clk;
  logic rst;

  ldifru_text_if text_ch ();
  ldifru_rec_if  rec_ch ();

  ldif_record_unfolder DUT (
    .clk  (clk),
    .rst  (rst),
    .text (text_ch),
    .rec  (rec_ch)
  );

  // Unfolding state of the predictor.
  bit comment_open;
  bit nl_pending;
  bit rec_has_bytes;
  bit seen_input;

  ldifru_pkg::result_t unfolded_q [$];
  text_beat_t          offered_text [$];

  int n_errors;
  int n_rand;
  int n_offered;
  int tx_mode;
  int burst_left;
  bit hold_req;
  bit hold_done;
  bit pause_done;

  // Short directed run: end of input, continuation, comments, blank lines, extremes.
  text_beat_t directed [N_DIRECTED] = '{
    '{8'hFF, 1'b1, 1'b1, 2'd1, EOI_NOTHING_MARK, NO_BEAT},
    '{8'h41, 1'b0, 1'b1, 2'd1, {8'h41, 1'b0, NO_KIND}, NO_BEAT},
    '{ldifru_pkg::CH_NEWLINE, 1'b0, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{ldifru_pkg::CH_SPACE, 1'b0, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{8'h42, 1'b0, 1'b1, 2'd1, {8'h42, 1'b0, NO_KIND}, NO_BEAT},
    '{ldifru_pkg::CH_NEWLINE, 1'b0, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{8'h43, 1'b0, 1'b1, 2'd2, NEWLINE_BYTE, {8'h43, 1'b0, NO_KIND}},
    '{ldifru_pkg::CH_NEWLINE, 1'b0, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{ldifru_pkg::CH_HASH, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{8'h78, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{ldifru_pkg::CH_NEWLINE, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{ldifru_pkg::CH_NEWLINE, 1'b0, 1'b1, 2'd1, BLANK_MARK, NO_BEAT},
    '{ldifru_pkg::CH_NEWLINE, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{ldifru_pkg::CH_HASH, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{8'h00, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{ldifru_pkg::CH_NEWLINE, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{8'hFF, 1'b0, 1'b1, 2'd1, {8'hFF, 1'b0, NO_KIND}, NO_BEAT},
    '{8'h00, 1'b0, 1'b1, 2'd1, {8'h00, 1'b0, NO_KIND}, NO_BEAT},
    '{ldifru_pkg::CH_HASH, 1'b0, 1'b1, 2'd1,
      {ldifru_pkg::CH_HASH, 1'b0, NO_KIND}, NO_BEAT},
    '{ldifru_pkg::CH_NEWLINE, 1'b0, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{8'h00, 1'b1, 1'b1, 2'd2, NEWLINE_BYTE, EOI_RECORD_MARK},
    '{8'h5A, 1'b0, 1'b1, 2'd1, {8'h5A, 1'b0, NO_KIND}, NO_BEAT},
    '{8'h5A, 1'b1, 1'b1, 2'd1, EOI_RECORD_MARK, NO_BEAT},
    '{ldifru_pkg::CH_NEWLINE, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{8'h80, 1'b1, 1'b1, 2'd1, EOI_RECORD_MARK, NO_BEAT},
    '{ldifru_pkg::CH_SPACE, 1'b0, 1'b1, 2'd1,
      {ldifru_pkg::CH_SPACE, 1'b0, NO_KIND}, NO_BEAT}
  };

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Works out the record beats that one text beat gives and moves the state on.
  function automatic void unfold_step(input logic [7:0] c, input logic eoi,
                                      output int n, output ldifru_pkg::result_t res [2]);
    n = 0;
    res[0] = NO_BEAT;
    res[1] = NO_BEAT;
    if (eoi) begin
      if (nl_pending) begin
        res[n] = NEWLINE_BYTE;
        n++;
      end
      res[n] = seen_input ? EOI_RECORD_MARK : EOI_NOTHING_MARK;
      n++;
      comment_open = 1'b0;
      nl_pending = 1'b0;
      rec_has_bytes = 1'b0;
      seen_input = 1'b0;
      return;
    end
    seen_input = 1'b1;
    if (comment_open) begin
      if (c == ldifru_pkg::CH_NEWLINE) comment_open = 1'b0;
      return;
    end
    // A space after a held newline folds the line.
    if (c == ldifru_pkg::CH_SPACE && nl_pending) begin
      nl_pending = 1'b0;
      return;
    end
    // Two newlines in a row close the record.
    if (c == ldifru_pkg::CH_NEWLINE && nl_pending) begin
      res[n] = BLANK_MARK;
      n++;
      comment_open = 1'b0;
      nl_pending = 1'b0;
      rec_has_bytes = 1'b0;
      seen_input = 1'b0;
      return;
    end
    if (c == ldifru_pkg::CH_HASH && (!rec_has_bytes || nl_pending)) begin
      comment_open = 1'b1;
      return;
    end
    if (c == ldifru_pkg::CH_NEWLINE && !rec_has_bytes) return;
    if (nl_pending) begin
      res[n] = NEWLINE_BYTE;
      n++;
      nl_pending = 1'b0;
    end
    if (c == ldifru_pkg::CH_NEWLINE) begin
      nl_pending = 1'b1;
    end else begin
      res[n] = {c, 1'b0, NO_KIND};
      n++;
    end
    rec_has_bytes = 1'b1;
  endfunction

  // Idle cycles before a beat: none, occasional, or drawn at random for each beat.
  function automatic int draw_gap(int mode);
    case (mode)
      0: return 0;
      1: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 18)) : 0;
      default: return $urandom_range(0, 18);
    endcase
  endfunction

  // Mostly printable characters, now and then any byte at all.
  function automatic logic [7:0] text_char();
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(8'h21, 8'h7E));
  endfunction

  // Noise leans on the characters with a meaning of their own.
  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 4))
      0: return ldifru_pkg::CH_NEWLINE;
      1: return ldifru_pkg::CH_SPACE;
      2: return ldifru_pkg::CH_HASH;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offers one text beat after its idle gap and returns at the edge that takes it.
  task automatic offer(input text_beat_t beat);
    int gap;
    if (n_offered % 64 == 0) tx_mode = $urandom_range(0, 2);
    n_offered++;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = draw_gap(tx_mode);
    end
    if (gap > 0) begin
      text_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    offered_text.push_back(beat);
    text_ch.valid        <= 1'b1;
    text_ch.in_byte      <= beat.data;
    text_ch.end_of_input <= beat.eoi;
    @(posedge clk);
    while (!text_ch.ready) @(posedge clk);
  endtask

  task automatic emit(input logic [7:0] b);
    offer({b, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT});
    n_rand++;
  endtask

  task automatic emit_eoi();
    offer({8'($urandom_range(0, 255)), 1'b1, 1'b0, 2'd0, NO_BEAT, NO_BEAT});
    n_rand++;
  endtask

  task automatic emit_comment();
    emit(ldifru_pkg::CH_HASH);
    repeat ($urandom_range(0, 6)) emit(text_char());
    emit(ldifru_pkg::CH_NEWLINE);
  endtask

  // Stops offering and waits until every record beat owed has come out.
  task automatic drain();
    text_ch.valid <= 1'b0;
    @(posedge clk);
    while (unfolded_q.size() != 0) @(posedge clk);
  endtask

  // One record of folded lines and comments with random content, or a burst of noise.
  task automatic gen_record();
    int n_lines;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) emit(noise_char());
      return;
    end
    repeat ($urandom_range(0, 2)) emit(ldifru_pkg::CH_NEWLINE);
    if ($urandom_range(0, 3) == 0) emit_comment();
    n_lines = $urandom_range(1, 4);
    for (int l = 0; l < n_lines; l++) begin
      repeat ($urandom_range(1, 8)) emit(text_char());
      emit(ldifru_pkg::CH_NEWLINE);
      if ($urandom_range(0, 2) == 0) begin
        emit(ldifru_pkg::CH_SPACE);
        repeat ($urandom_range(1, 6)) emit(text_char());
        emit(ldifru_pkg::CH_NEWLINE);
      end
      if ($urandom_range(0, 4) == 0) emit_comment();
    end
    case ($urandom_range(0, 7))
      0: emit_eoi();
      1: begin
        emit_eoi();
        emit_eoi();
      end
      2: begin
        // A comment still open when the input ends.
        emit(ldifru_pkg::CH_HASH);
        emit(text_char());
        emit_eoi();
      end
      default: emit(ldifru_pkg::CH_NEWLINE);
    endcase
  endtask

  // Record side: stalls at random, and once for a long stretch on request.
  initial begin
    int wait_cycles;
    int n_taken;
    int rx_mode;
    n_taken = 0;
    rx_mode = 2;
    rec_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (n_taken % 64 == 0) rx_mode = $urandom_range(0, 2);
      if (hold_req) begin
        hold_req = 1'b0;
        wait_cycles = HOLD_CYCLES;
      end else begin
        wait_cycles = draw_gap(rx_mode);
      end
      if (wait_cycles > 0) begin
        rec_ch.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      rec_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rec_ch.valid) @(posedge clk);
      n_taken++;
    end
  end

  // Checks each record beat against the oldest one owed, then books what a text beat owes.
  always @(posedge clk) begin : beat_monitor
    ldifru_pkg::result_t got;
    ldifru_pkg::result_t want;
    ldifru_pkg::result_t pred [2];
    int n_pred;
    if (!rst) begin
      if (rec_ch.valid && rec_ch.ready) begin
        got = {rec_ch.out_byte, rec_ch.record_end, rec_ch.end_kind};
        if (unfolded_q.size() == 0) begin
          $error("record beat with none owed: out_byte %02h record_end %0b end_kind %0d",
                 got.out_byte, got.record_end, got.end_kind);
          n_errors++;
        end else begin
          want = unfolded_q.pop_front();
          if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
            n_errors++;
          end
          if (got.record_end !== want.record_end) begin
            $error("record_end: expected %0b, got %0b", want.record_end, got.record_end);
            n_errors++;
          end
          if (got.end_kind !== want.end_kind) begin
            $error("end_kind: expected %0d, got %0d", want.end_kind, got.end_kind);
            n_errors++;
          end
        end
      end
      if (text_ch.valid && text_ch.ready) begin
        unfold_step(text_ch.in_byte, text_ch.end_of_input, n_pred, pred);
        if (offered_text[0].typed) begin
          if (offered_text[0].n_res > 2'd0) unfolded_q.push_back(offered_text[0].r0);
          if (offered_text[0].n_res > 2'd1) unfolded_q.push_back(offered_text[0].r1);
        end else begin
          for (int k = 0; k < n_pred; k++) unfolded_q.push_back(pred[k]);
        end
        void'(offered_text.pop_front());
      end
    end
  end

  // Watchdog.
  initial begin
    int cycle_count;
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("ldif_record_unfolder regression: fail");
        $finish;
      end
    end
  end

  // Reset, directed run, random records with one long stall and one pause, then the verdict.
  initial begin
    text_ch.valid        <= 1'b0;
    text_ch.in_byte      <= 8'h00;
    text_ch.end_of_input <= 1'b0;
    rst <= 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) offer(directed[i]);
    drain();

    while (n_rand < RANDOM_ITEMS) begin
      if (!hold_done && n_rand >= 500) begin
        // The record side holds off while text keeps coming back to back.
        hold_done = 1'b1;
        hold_req = 1'b1;
        burst_left = 150;
      end
      if (!pause_done && n_rand >= 1100) begin
        pause_done = 1'b1;
        drain();
      end
      gen_record();
    end
    drain();
    repeat (40) @(posedge clk);

    if (n_errors == 0) begin
      $display("ldif_record_unfolder regression: pass");
    end else begin
      $display("ldif_record_unfolder regression: fail");
    end
    $finish;
  end

endmodule
